### sv/btc_pkg.sv
// ----------------------------------------------------------------------------
// btc_pkg
// Types and constants shared by the sensor compensation pipeline.
// ----------------------------------------------------------------------------
package btc_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

    // Arithmetic constants.
    localparam logic [29:0]        HUMID_SCALE  = 30'd12500;
    localparam logic signed [14:0] HUMID_MIN    = -15'sd600;
    localparam logic signed [14:0] HUMID_MAX    = 15'sd11899;
    localparam logic signed [19:0] TEMP_BASE    = 20'sd2000;
    localparam logic signed [19:0] LOW_OFFSET   = 20'sd3500;   // 2000 + 1500
    localparam logic signed [18:0] LOW_LIMIT    = -19'sd3500;  // -1500 relative to 2000
    localparam logic signed [19:0] TEMP_SAT_MAX = 20'sd32767;
    localparam logic signed [19:0] TEMP_SAT_MIN = -20'sd32768;
    localparam logic [17:0]        PRESS_MAX    = 18'h3FFFF;

    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] offset;
        logic [15:0] sens_temp;
        logic [15:0] offset_temp;
        logic [15:0] ref_temp;
        logic [15:0] temp_slope;
    } cfg_t;

    typedef struct packed {
        logic [15:0] raw_humid;
        logic [23:0] raw_temp;
        logic [23:0] raw_press;
    } sample_t;

    // First-order results.
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [14:0] humid;
        logic signed [18:0] q6;     // TEMP - 2000
        logic [17:0]        t2;
        logic signed [36:0] off;
        logic signed [35:0] sens;
    } front_t;

    // Second-order corrected values.
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [14:0] humid;
        logic signed [15:0] temp;
        logic signed [41:0] off_net;
        logic signed [41:0] sens_net;
    } corr_t;

    typedef struct packed {
        logic signed [14:0] humid_centi;
        logic [17:0]        press_pa;
        logic signed [15:0] temp_centi;
    } result_t;

endpackage

### sv/baro_temp_humidity_compensation.sv
// ----------------------------------------------------------------------------
// baro_temp_humidity_compensation
// Compensated temperature, pressure and humidity from raw sensor readings.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         raw pressure, raw temperature, raw humidity
//  m_*       out        temperature 0.01 C, pressure Pa, humidity 0.01 %
//  cfg_*     in         calibration word writes, index 0 to 5
//
//  One sample set is accepted per cycle while s_tready is high; each result
//  passes through a ten-stage pipeline whose longest path is one multiplier
//  of at most 25 by 25 bits.
//  Reset clears the stage valid bits and the calibration words.
//  A stall on m_tready fills empty stages first and then holds s_tready low.
//  Calibration writes are always ready and take effect on the next cycle.
module baro_temp_humidity_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // raw_press[23:0], raw_temp[47:24], raw_humid[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,     // temp_centi[15:0], press_pa[33:16], humid_centi[48:34]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data
);
    import btc_pkg::*;

    cfg_t    cfg_reg;
    sample_t sample;
    front_t  front_data;
    corr_t   corr_data;
    result_t result_data;
    logic    front_valid;
    logic    front_ready;
    logic    corr_valid;
    logic    corr_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SENS:        cfg_reg.sens        <= cfg_data;
                REG_OFFSET:      cfg_reg.offset      <= cfg_data;
                REG_SENS_TEMP:   cfg_reg.sens_temp   <= cfg_data;
                REG_OFFSET_TEMP: cfg_reg.offset_temp <= cfg_data;
                REG_REF_TEMP:    cfg_reg.ref_temp    <= cfg_data;
                REG_TEMP_SLOPE:  cfg_reg.temp_slope  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign sample.raw_press = s_tdata[23:0];
    assign sample.raw_temp  = s_tdata[47:24];
    assign sample.raw_humid = s_tdata[63:48];

    btc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (sample),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    btc_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (corr_valid),
        .out_ready (corr_ready),
        .out_data  (corr_data)
    );

    btc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (corr_valid),
        .in_ready  (corr_ready),
        .in_data   (corr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (result_data)
    );

    assign m_tdata = {7'd0, result_data.humid_centi, result_data.press_pa,
                      result_data.temp_centi};

endmodule

### sv/btc_front.sv
// ----------------------------------------------------------------------------
// btc_front
// Stages one to three: temperature difference, first-order products,
// scaled temperature, offset and sensitivity, and humidity.
// ----------------------------------------------------------------------------
module btc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  btc_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_ready,
    input  btc_pkg::sample_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output btc_pkg::front_t  out_data
);
    import btc_pkg::*;

    logic [2:0] v_reg;
    logic [2:0] en;

    // Stage one.
    logic signed [24:0] dt_next;
    logic [29:0]        hprod_next;
    logic signed [24:0] dt_s1_reg;
    logic [29:0]        hprod_s1_reg;
    logic [23:0]        d1_s1_reg;

    // Stage two.
    logic signed [41:0] p6_next;
    logic signed [41:0] p4_next;
    logic signed [41:0] p3_next;
    logic signed [49:0] dsq_next;
    logic signed [14:0] humid_next;
    logic signed [41:0] p6_s2_reg;
    logic signed [41:0] p4_s2_reg;
    logic signed [41:0] p3_s2_reg;
    logic signed [49:0] dsq_s2_reg;
    logic signed [14:0] humid_s2_reg;
    logic [23:0]        d1_s2_reg;

    // Stage three.
    front_t             front_next;
    front_t             front_reg;

    always_comb begin
        en[2] = !v_reg[2] || out_ready;
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_data  = front_reg;

    always_comb begin
        dt_next    = $signed({1'b0, in_data.raw_temp}) - $signed({1'b0, cfg.ref_temp, 8'd0});
        hprod_next = 30'(in_data.raw_humid) * HUMID_SCALE;
    end

    always_comb begin
        p6_next    = dt_s1_reg * $signed({1'b0, cfg.temp_slope});
        p4_next    = dt_s1_reg * $signed({1'b0, cfg.offset_temp});
        p3_next    = dt_s1_reg * $signed({1'b0, cfg.sens_temp});
        dsq_next   = dt_s1_reg * dt_s1_reg;
        humid_next = $signed({1'b0, hprod_s1_reg[29:16]}) + HUMID_MIN;
    end

    // Arithmetic shifts of the products are taken as upper bit slices.
    always_comb begin
        front_next.d1    = d1_s2_reg;
        front_next.humid = humid_s2_reg;
        front_next.q6    = p6_s2_reg[41:23];
        front_next.t2    = dsq_s2_reg[48:31];
        front_next.off   = $signed({4'b0, cfg.offset, 17'd0})
                         + 37'($signed(p4_s2_reg[41:6]));
        front_next.sens  = $signed({4'b0, cfg.sens, 16'd0})
                         + 36'($signed(p3_s2_reg[41:7]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dt_s1_reg    <= dt_next;
            hprod_s1_reg <= hprod_next;
            d1_s1_reg    <= in_data.raw_press;
        end
        if (en[1]) begin
            p6_s2_reg    <= p6_next;
            p4_s2_reg    <= p4_next;
            p3_s2_reg    <= p3_next;
            dsq_s2_reg   <= dsq_next;
            humid_s2_reg <= humid_next;
            d1_s2_reg    <= d1_s1_reg;
        end
        if (en[2]) begin
            front_reg <= front_next;
        end
    end

endmodule

### sv/btc_corr.sv
// ----------------------------------------------------------------------------
// btc_corr
// Stages four to six: second-order correction terms below 20 C and
// -15 C, temperature saturation, and the corrected offset and sensitivity.
// ----------------------------------------------------------------------------
module btc_corr (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  btc_pkg::front_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output btc_pkg::corr_t  out_data
);
    import btc_pkg::*;

    logic [2:0] v_reg;
    logic [2:0] en;

    // Stage four.
    logic signed [37:0] a_sq;
    logic signed [19:0] b_val;
    logic signed [39:0] b_sq;
    logic signed [19:0] temp_full_next;
    logic [36:0]        aa_s4_reg;
    logic [36:0]        bb_s4_reg;
    logic               cold_s4_reg;
    logic               frost_s4_reg;
    logic signed [19:0] temp_full_s4_reg;
    logic [23:0]        d1_s4_reg;
    logic signed [14:0] humid_s4_reg;
    logic signed [36:0] off_s4_reg;
    logic signed [35:0] sens_s4_reg;

    // Stage five.
    logic [38:0]        five_aa;
    logic [37:0]        off2a;
    logic [39:0]        seven_bb;
    logic [39:0]        eleven_bb;
    logic [39:0]        off2_next;
    logic [39:0]        sens2_next;
    logic signed [15:0] temp_next;
    logic [39:0]        off2_s5_reg;
    logic [39:0]        sens2_s5_reg;
    logic signed [15:0] temp_s5_reg;
    logic [23:0]        d1_s5_reg;
    logic signed [14:0] humid_s5_reg;
    logic signed [36:0] off_s5_reg;
    logic signed [35:0] sens_s5_reg;

    // Stage six.
    corr_t              corr_next;
    corr_t              corr_reg;

    always_comb begin
        en[2] = !v_reg[2] || out_ready;
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[2];
    assign out_data  = corr_reg;

    // q6 is TEMP - 2000, so TEMP + 1500 is q6 + 3500.
    always_comb begin
        a_sq  = in_data.q6 * in_data.q6;
        b_val = 20'(in_data.q6) + LOW_OFFSET;
        b_sq  = b_val * b_val;
        temp_full_next = 20'(in_data.q6) + TEMP_BASE
                       - (in_data.q6[18] ? $signed({2'b0, in_data.t2}) : 20'sd0);
    end

    always_comb begin
        five_aa   = {2'b0, aa_s4_reg} + {aa_s4_reg, 2'b0};
        off2a     = five_aa[38:1];
        seven_bb  = {bb_s4_reg, 3'b0} - {3'b0, bb_s4_reg};
        eleven_bb = {bb_s4_reg, 3'b0} + {2'b0, bb_s4_reg, 1'b0} + {3'b0, bb_s4_reg};
        if (cold_s4_reg) begin
            off2_next  = 40'(off2a) + (frost_s4_reg ? seven_bb : 40'd0);
            sens2_next = 40'(off2a[37:1]) + (frost_s4_reg ? 40'(eleven_bb[39:1]) : 40'd0);
        end else begin
            off2_next  = '0;
            sens2_next = '0;
        end
        if (temp_full_s4_reg > TEMP_SAT_MAX) begin
            temp_next = TEMP_SAT_MAX[15:0];
        end else if (temp_full_s4_reg < TEMP_SAT_MIN) begin
            temp_next = TEMP_SAT_MIN[15:0];
        end else begin
            temp_next = temp_full_s4_reg[15:0];
        end
    end

    always_comb begin
        corr_next.d1       = d1_s5_reg;
        corr_next.humid    = humid_s5_reg;
        corr_next.temp     = temp_s5_reg;
        corr_next.off_net  = 42'(off_s5_reg) - $signed({2'b0, off2_s5_reg});
        corr_next.sens_net = 42'(sens_s5_reg) - $signed({2'b0, sens2_s5_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            aa_s4_reg        <= a_sq[36:0];
            bb_s4_reg        <= b_sq[36:0];
            cold_s4_reg      <= in_data.q6[18];
            frost_s4_reg     <= in_data.q6 < LOW_LIMIT;
            temp_full_s4_reg <= temp_full_next;
            d1_s4_reg        <= in_data.d1;
            humid_s4_reg     <= in_data.humid;
            off_s4_reg       <= in_data.off;
            sens_s4_reg      <= in_data.sens;
        end
        if (en[1]) begin
            off2_s5_reg  <= off2_next;
            sens2_s5_reg <= sens2_next;
            temp_s5_reg  <= temp_next;
            d1_s5_reg    <= d1_s4_reg;
            humid_s5_reg <= humid_s4_reg;
            off_s5_reg   <= off_s4_reg;
            sens_s5_reg  <= sens_s4_reg;
        end
        if (en[2]) begin
            corr_reg <= corr_next;
        end
    end

endmodule

### sv/btc_press.sv
// ----------------------------------------------------------------------------
// btc_press
// Stages seven to ten: split pressure product, scaling, offset removal and
// clamping. The last stage is the result register of the block.
// ----------------------------------------------------------------------------
module btc_press (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  btc_pkg::corr_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output btc_pkg::result_t out_data
);
    import btc_pkg::*;

    logic [3:0] v_reg;
    logic [3:0] en;

    // Stage seven: the 24 x 42 product is taken as two partial products.
    logic [44:0]        pl_next;
    logic signed [45:0] ph_next;
    logic [44:0]        pl_s7_reg;
    logic signed [45:0] ph_s7_reg;
    logic signed [41:0] off_s7_reg;
    logic signed [15:0] temp_s7_reg;
    logic signed [14:0] humid_s7_reg;

    // Stage eight.
    logic signed [46:0] q_next;
    logic signed [46:0] q_s8_reg;
    logic signed [41:0] off_s8_reg;
    logic signed [15:0] temp_s8_reg;
    logic signed [14:0] humid_s8_reg;

    // Stage nine.
    logic signed [47:0] diff_next;
    logic signed [47:0] diff_s9_reg;
    logic signed [15:0] temp_s9_reg;
    logic signed [14:0] humid_s9_reg;

    // Stage ten.
    result_t            result_next;
    result_t            result_reg;

    always_comb begin
        en[3] = !v_reg[3] || out_ready;
        en[2] = !v_reg[2] || en[3];
        en[1] = !v_reg[1] || en[2];
        en[0] = !v_reg[0] || en[1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[3];
    assign out_data  = result_reg;

    always_comb begin
        pl_next = 45'(in_data.d1) * 45'(in_data.sens_net[20:0]);
        ph_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens_net[41:21]);
    end

    // The low partial product is never negative, so the shift by 21 adds
    // only its upper bits to the high partial product.
    always_comb begin
        q_next    = 47'(ph_s7_reg) + $signed({23'b0, pl_s7_reg[44:21]});
        diff_next = 48'(q_s8_reg) - 48'(off_s8_reg);
    end

    always_comb begin
        result_next.temp_centi  = temp_s9_reg;
        result_next.humid_centi = humid_s9_reg;
        if (diff_s9_reg[47]) begin
            result_next.press_pa = '0;
        end else if (|diff_s9_reg[46:33]) begin
            result_next.press_pa = PRESS_MAX;
        end else begin
            result_next.press_pa = diff_s9_reg[32:15];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (en[0]) v_reg[0] <= in_valid;
            if (en[1]) v_reg[1] <= v_reg[0];
            if (en[2]) v_reg[2] <= v_reg[1];
            if (en[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pl_s7_reg    <= pl_next;
            ph_s7_reg    <= ph_next;
            off_s7_reg   <= in_data.off_net;
            temp_s7_reg  <= in_data.temp;
            humid_s7_reg <= in_data.humid;
        end
        if (en[1]) begin
            q_s8_reg     <= q_next;
            off_s8_reg   <= off_s7_reg;
            temp_s8_reg  <= temp_s7_reg;
            humid_s8_reg <= humid_s7_reg;
        end
        if (en[2]) begin
            diff_s9_reg  <= diff_next;
            temp_s9_reg  <= temp_s8_reg;
            humid_s9_reg <= humid_s8_reg;
        end
        if (en[3]) begin
            result_reg <= result_next;
        end
    end

endmodule

### sv/btc_checker.sv
// ----------------------------------------------------------------------------
// btc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module btc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import btc_pkg::*;

    // A result waiting on the output must hold still.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With the output free, the pipeline must take a new sample set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tready || !m_tvalid) |-> s_tready)
        else $error("input stalled while output is free");

    // Humidity stays within its defined range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[48:34]) >= HUMID_MIN)
                  && ($signed(m_tdata[48:34]) <= HUMID_MAX))
        else $error("humidity out of range");

endmodule

bind baro_temp_humidity_compensation btc_checker u_checker (.*);
